FILE: rtl/pss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int VALUE_W_DEF = 32;
    localparam int POS_W       = 8;
    localparam int FIDX_W      = 6;
    localparam int LEN_W       = 7;
    // index field in the cell control bus, wide enough for the largest depth
    localparam int CELL_IDX_W  = 10;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_REMOVE = 3'd1,
        K_ERASE  = 3'd2,
        K_FIND   = 3'd3,
        K_EDIT   = 3'd4,
        K_GET    = 3'd5,
        K_CLEAR  = 3'd6,
        K_LENGTH = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_WRITE,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [CELL_IDX_W-1:0] idx;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/pss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_cell
// One storage slot of the sequence; takes from its neighbors on shifts.
// ----------------------------------------------------------------------------
module pss_cell
    import pss_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  wire logic                   i_clk,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_left,
    input  wire logic [VALUE_WIDTH-1:0] i_right,
    input  wire logic [VALUE_WIDTH-1:0] i_head,
    output logic      [VALUE_WIDTH-1:0] o_value
);

    localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX > i_ctrl.idx) begin
                    n_value = i_left;
                end else if (MY_IDX == i_ctrl.idx) begin
                    n_value = i_value;
                end
            end
            CELL_ERASE: begin
                if (MY_IDX >= i_ctrl.idx) begin
                    n_value = i_right;
                end
            end
            CELL_WRITE: begin
                if (MY_IDX == i_ctrl.idx) begin
                    n_value = i_value;
                end
            end
            CELL_SHIFT: begin
                n_value = i_right;
            end
            CELL_ROTATE: begin
                // head element re-enters at the tail of the live region
                n_value = (MY_IDX == i_ctrl.idx) ? i_head : i_right;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

FILE: rtl/positional_sequence_store.sv
// ----------------------------------------------------------------------------
// positional_sequence_store: ordered list held in a row of shifting cells
// Insert, erase, edit, clear, length, out-of-range get: result registered in
//   the cycle after the transfer, one item per cycle unless the output stalls.
//   Remove, find, get: result after one full rotation of the list through the
//   head cell; no new item is taken meanwhile. Reset: empty.
`timescale 1ns / 1ps
`default_nettype none
module positional_sequence_store
    import pss_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [2:0]                    i_kind,
    input  wire logic [POS_W-1:0]              i_position,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic signed [VALUE_WIDTH-1:0]      o_read_value,
    output logic [FIDX_W-1:0]                  o_found_index,
    output logic [LEN_W-1:0]                   o_length,
    output logic                               o_is_empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;

    // scan context
    t_kind              r_kind;
    logic [POS_W-1:0]   r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_occ;
    logic               r_found;
    logic [IDX_W-1:0]   r_fidx;
    logic [VALUE_WIDTH-1:0] r_rd;

    // result register
    t_status            r_status;
    logic [VALUE_WIDTH-1:0] r_read_value;
    logic [FIDX_W-1:0]  r_found_index;
    logic [LEN_W-1:0]   r_length;
    logic               r_is_empty;

    logic               w_out_free;
    logic               w_in_fire;
    logic               w_load;
    logic               w_scan_start;
    logic               w_scan_last;
    t_kind              w_kind;
    logic [CMP_W-1:0]   w_pos_cmp;
    logic [CMP_W-1:0]   w_cnt_cmp;
    logic [CMP_W-1:0]   w_ins_pos;
    logic               w_pos_ge_cnt;
    logic               w_full;
    logic               w_match;
    logic               w_keep;
    logic [CNT_W-1:0]   w_n_occ;
    logic               w_get_hit;
    t_cell_ctrl         w_ctrl;
    t_status            w_res_status;
    logic [VALUE_WIDTH-1:0] w_res_rd;
    logic [FIDX_W-1:0]  w_res_fidx;

    logic [VALUE_WIDTH-1:0] w_cell_val [DEPTH];
    logic [VALUE_WIDTH-1:0] w_head;

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell_val[0];
        end else begin : g_mid_l
            assign w_left = w_cell_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell_val[DEPTH-1];
        end else begin : g_mid_r
            assign w_right = w_cell_val[g+1];
        end

        pss_cell #(
            .INDEX       (g),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .o_value (w_cell_val[g])
        );
    end

    assign w_head = w_cell_val[0];

    // ------------------------------------------------------------------
    // decode
    // ------------------------------------------------------------------
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_in_fire    = i_in_valid && !o_in_stall;
    assign w_kind       = t_kind'(i_kind);
    assign w_pos_cmp    = CMP_W'(i_position);
    assign w_cnt_cmp    = CMP_W'(r_count);
    assign w_pos_ge_cnt = (w_pos_cmp >= w_cnt_cmp);
    assign w_ins_pos    = (w_pos_cmp > w_cnt_cmp) ? w_cnt_cmp : w_pos_cmp;
    assign w_full       = (r_count == CNT_W'(DEPTH));

    assign w_match      = (w_head == r_val);
    assign w_keep       = !((r_kind == K_REMOVE) && w_match);
    assign w_n_occ      = w_keep ? r_occ : (r_occ - CNT_W'(1));
    assign w_scan_last  = (r_k == (r_n - CNT_W'(1)));
    assign w_get_hit    = (CMP_W'(r_k) == CMP_W'(r_pos));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_scan_start) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall   = 1'b1;
        w_ctrl       = '{op: CELL_HOLD, idx: '0};
        n_count      = r_count;
        w_load       = 1'b0;
        w_scan_start = 1'b0;
        w_res_status = STAT_OK;
        w_res_rd     = '0;
        w_res_fidx   = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !w_out_free;
                if (w_in_fire) begin
                    case (w_kind)
                        K_INSERT: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_res_status = STAT_FULL;
                            end else begin
                                w_ctrl  = '{op: CELL_INSERT, idx: CELL_IDX_W'(w_ins_pos)};
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        K_REMOVE, K_FIND: begin
                            w_scan_start = 1'b1;
                        end
                        K_ERASE: begin
                            w_load = 1'b1;
                            if (w_pos_ge_cnt) begin
                                w_res_status = STAT_RANGE;
                            end else begin
                                w_ctrl  = '{op: CELL_ERASE, idx: CELL_IDX_W'(i_position)};
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        K_EDIT: begin
                            w_load = 1'b1;
                            if (w_pos_ge_cnt) begin
                                w_res_status = STAT_RANGE;
                            end else begin
                                w_ctrl = '{op: CELL_WRITE, idx: CELL_IDX_W'(i_position)};
                            end
                        end
                        K_GET: begin
                            if (w_pos_ge_cnt) begin
                                w_load       = 1'b1;
                                w_res_status = STAT_RANGE;
                            end else begin
                                w_scan_start = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            w_load  = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // pop the head; kept elements go back in at the live tail
                if (w_keep) begin
                    w_ctrl = '{op: CELL_ROTATE, idx: CELL_IDX_W'(r_occ - CNT_W'(1))};
                end else begin
                    w_ctrl = '{op: CELL_SHIFT, idx: '0};
                end
                if (w_scan_last) begin
                    n_count = w_n_occ;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    case (r_kind)
                        K_GET: begin
                            w_res_rd = r_rd;
                        end
                        K_FIND: begin
                            w_res_status = r_found ? STAT_OK : STAT_NOTFOUND;
                            w_res_fidx   = FIDX_W'(r_fidx);
                        end
                        K_REMOVE: begin
                            w_res_status = r_found ? STAT_OK : STAT_NOTFOUND;
                        end
                        default: begin
                            w_res_status = STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_start) begin
            r_kind  <= w_kind;
            r_pos   <= i_position;
            r_val   <= i_value;
            r_k     <= '0;
            r_n     <= r_count;
            r_occ   <= r_count;
            r_found <= 1'b0;
            r_fidx  <= '0;
            r_rd    <= '0;
        end else if (r_state == ST_SCAN) begin
            r_k     <= r_k + CNT_W'(1);
            r_occ   <= w_n_occ;
            r_found <= r_found | w_match;
            if ((r_kind == K_FIND) && w_match && !r_found) begin
                r_fidx <= r_k[IDX_W-1:0];
            end
            if ((r_kind == K_GET) && w_get_hit) begin
                r_rd <= w_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status      <= w_res_status;
            r_read_value  <= w_res_rd;
            r_found_index <= w_res_fidx;
            r_length      <= LEN_W'(n_count);
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_found_index = r_found_index;
    assign o_length      = r_length;
    assign o_is_empty    = r_is_empty;

endmodule
`default_nettype wire

FILE: test/tb_positional_sequence_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_sequence_store
// Drives insert, remove, erase, find, edit, get, clear and length operations
// into the ordered list store. A shadow copy of the list predicts each reply,
// and every reply is checked field by field, in order, under random
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_positional_sequence_store;
    import pss_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int POOL_SIZE   = 12;
    localparam int STUCK_LIMIT = 50000;
    localparam int TAIL_CYCLES = LIST_DEPTH + 16;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic [5:0]  found_index;
        logic [6:0]  length;
        logic        is_empty;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_kind = K_LENGTH;
    logic [POS_W-1:0]  i_position = '0;
    logic [31:0]       i_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic [31:0]       o_read_value;
    logic [FIDX_W-1:0] o_found_index;
    logic [LEN_W-1:0]  o_length;
    logic              o_is_empty;

    // shadow copy of the stored sequence
    logic [31:0] shadow_elems [LIST_DEPTH];
    int          shadow_len = 0;
    logic [31:0] value_pool [POOL_SIZE];

    t_reply due_results [$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     stuck_cycles = 0;

    positional_sequence_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found_index (o_found_index),
        .o_length      (o_length),
        .o_is_empty    (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one operation to the shadow list and returns the reply it owes.
    function automatic t_reply predict_sequence_op(t_kind k, logic [POS_W-1:0] pos,
                                                   logic [31:0] v);
        t_reply r;
        int     p;
        int     i;
        int     keep;
        bit     hit;
        r = '0;
        r.status = STAT_OK;
        p = int'(pos);
        case (k)
            K_INSERT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (p > shadow_len) p = shadow_len;
                    for (i = shadow_len; i > p; i--) shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[p] = v;
                    shadow_len++;
                end
            end
            K_REMOVE: begin
                // drop every match, compacting the survivors
                keep = 0;
                hit = 1'b0;
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_elems[i] == v) begin
                        hit = 1'b1;
                    end else begin
                        shadow_elems[keep] = shadow_elems[i];
                        keep++;
                    end
                end
                if (hit) shadow_len = keep;
                else r.status = STAT_NOTFOUND;
            end
            K_ERASE: begin
                if (p >= shadow_len) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (i = p; i + 1 < shadow_len; i++) shadow_elems[i] = shadow_elems[i+1];
                    shadow_len--;
                end
            end
            K_FIND: begin
                hit = 1'b0;
                for (i = 0; i < shadow_len && !hit; i++) begin
                    if (shadow_elems[i] == v) begin
                        hit = 1'b1;
                        r.found_index = i[5:0];
                    end
                end
                if (!hit) r.status = STAT_NOTFOUND;
            end
            K_EDIT: begin
                if (p >= shadow_len) r.status = STAT_RANGE;
                else shadow_elems[p] = v;
            end
            K_GET: begin
                if (p >= shadow_len) r.status = STAT_RANGE;
                else r.read_value = shadow_elems[p];
            end
            K_CLEAR: shadow_len = 0;
            default: ;
        endcase
        r.length = shadow_len[6:0];
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    // Mostly pooled values so that find and remove hit; the rest fully random.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 70) return value_pool[$urandom_range(POOL_SIZE-1)];
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (r < 65) return POS_W'($urandom_range(shadow_len));
        if (r < 80) return POS_W'((shadow_len > 0) ? shadow_len - 1 : 0);
        return POS_W'($urandom_range(255));
    endfunction

    // One transfer on the input channel; the reply is predicted on acceptance.
    task automatic send_item(t_kind k, logic [POS_W-1:0] pos, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= k;
        i_position <= pos;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        due_results.push_back(predict_sequence_op(k, pos, v));
    endtask

    task automatic wait_for_quiet();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(K_LENGTH, 0, 0);
        send_item(K_GET, 0, 0);
        send_item(K_ERASE, 0, 0);
        send_item(K_EDIT, 0, 32'd5);
        send_item(K_FIND, 0, 32'd5);
        send_item(K_REMOVE, 0, 32'd5);
        // insert past the end appends
        send_item(K_INSERT, 8'd255, 32'h8000_0000);
        send_item(K_INSERT, 8'd0, 32'h7fff_ffff);
        send_item(K_INSERT, 8'd1, 32'hffff_ffff);
        send_item(K_INSERT, 8'd255, 32'h0000_0000);
        send_item(K_INSERT, 8'd2, 32'hffff_ffff);
        send_item(K_FIND, 0, 32'hffff_ffff);
        send_item(K_GET, 8'd4, 0);
        send_item(K_GET, 8'd5, 0);
        send_item(K_GET, 8'd255, 0);
        send_item(K_EDIT, 8'd0, 32'd1);
        send_item(K_EDIT, 8'd5, 32'd2);
        send_item(K_REMOVE, 8'd255, 32'hffff_ffff);
        send_item(K_ERASE, 8'd3, 0);
        send_item(K_ERASE, 8'd2, 0);
        send_item(K_ERASE, 8'd0, 0);
        send_item(K_GET, 8'd0, 0);
        send_item(K_CLEAR, 8'd255, 32'hffff_ffff);
        send_item(K_LENGTH, 8'd255, 32'hffff_ffff);
        // stale cells behind a clear must not match
        send_item(K_FIND, 0, 32'h0000_0000);
    endtask

    task automatic test_full_store();
        while (shadow_len < LIST_DEPTH) send_item(K_INSERT, POS_W'($urandom_range(255)), pick_value());
        send_item(K_INSERT, 8'd0, pick_value());
        send_item(K_GET, POS_W'(LIST_DEPTH - 1), 0);
        send_item(K_EDIT, POS_W'(LIST_DEPTH - 1), $urandom);
        send_item(K_FIND, 0, shadow_elems[LIST_DEPTH-1]);
        send_item(K_ERASE, POS_W'(LIST_DEPTH - 1), 0);
        send_item(K_INSERT, 8'd0, pick_value());
        send_item(K_INSERT, 8'd255, pick_value());
        send_item(K_LENGTH, 0, 0);
        send_item(K_REMOVE, 0, shadow_elems[0]);
        send_item(K_GET, POS_W'($urandom_range(255)), 0);
        send_item(K_CLEAR, 0, 0);
    endtask

    task automatic test_random(int n_items);
        t_kind       k;
        logic [31:0] v;
        int          r;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if (r < 38)      k = K_INSERT;
            else if (r < 44) k = K_REMOVE;
            else if (r < 56) k = K_ERASE;
            else if (r < 66) k = K_FIND;
            else if (r < 76) k = K_EDIT;
            else if (r < 90) k = K_GET;
            else if (r < 92) k = K_CLEAR;
            else             k = K_LENGTH;
            v = pick_value();
            if ((k == K_FIND || k == K_REMOVE) && shadow_len > 0 && $urandom_range(1))
                v = shadow_elems[$urandom_range(shadow_len - 1)];
            send_item(k, pick_position(), v);
            if ($urandom_range(99) == 0) wait_for_quiet();
        end
    endtask

    function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // output side: random stall, and check each transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    note_mismatch("unexpected reply, status", 32'hx, 32'(o_status));
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(o_status));
                    if (o_read_value !== want.read_value)
                        note_mismatch("read_value", want.read_value, o_read_value);
                    if (o_found_index !== want.found_index)
                        note_mismatch("found_index", 32'(want.found_index), 32'(o_found_index));
                    if (o_length !== want.length)
                        note_mismatch("length", 32'(want.length), 32'(o_length));
                    if (o_is_empty !== want.is_empty)
                        note_mismatch("is_empty", 32'(want.is_empty), 32'(o_is_empty));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h8000_0000;
        value_pool[2] = 32'h7fff_ffff;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_stall_pct = 52;
        test_directed();
        test_full_store();
        test_random(340);
        wait_for_quiet();

        send_idle_pct = 52;
        recv_stall_pct = 34;
        test_full_store();
        test_random(340);
        wait_for_quiet();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(340);
        test_full_store();

        wait_for_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pss_pkg.sv
rtl/pss_cell.sv
rtl/positional_sequence_store.sv
test/tb_positional_sequence_store.sv
